@@ sv/bft_pkg.sv @@
`timescale 1ns / 1ps

package bft_pkg;

    localparam int MAX_BINS  = 16;
    localparam int MAX_ITEMS = 16;
    localparam int SIZE_W    = 16;

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int SLOT_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int ADDR_W = BIN_W + SLOT_W;
    localparam int SUM_W  = SIZE_W + 1;
    localparam int ACT_W  = 3;
    localparam int STS_W  = 3;

    localparam logic [ACT_W-1:0] OP_ADD_BIN  = 3'd0;
    localparam logic [ACT_W-1:0] OP_CONTAINS = 3'd1;
    localparam logic [ACT_W-1:0] OP_FIT      = 3'd2;
    localparam logic [ACT_W-1:0] OP_INSERT   = 3'd3;
    localparam logic [ACT_W-1:0] OP_REMOVE   = 3'd4;
    localparam logic [ACT_W-1:0] OP_MOVE     = 3'd5;
    localparam logic [ACT_W-1:0] OP_SWAP     = 3'd6;
    localparam logic [ACT_W-1:0] OP_COMPACT  = 3'd7;

    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd1;
    localparam logic [STS_W-1:0] STS_OVER_CAP  = 3'd2;
    localparam logic [STS_W-1:0] STS_BAD_BIN   = 3'd3;
    localparam logic [STS_W-1:0] STS_FULL      = 3'd4;

    typedef struct packed {
        logic              clr;
        logic              valid;
        logic [SLOT_W-1:0] idx;
    } match_ctl_t;

    typedef struct packed {
        logic [1:0]        hits0;
        logic [SLOT_W-1:0] idx0;
        logic              hit1;
    } match_res_t;

endpackage

@@ sv/bft_slot_ram.sv @@
`timescale 1ns / 1ps

module bft_slot_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/bft_match.sv @@
`timescale 1ns / 1ps

module bft_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bft_pkg::match_ctl_t           ctl,
    input  logic [bft_pkg::SIZE_W-1:0]    data,
    input  logic [bft_pkg::SIZE_W-1:0]    key0,
    input  logic [bft_pkg::SIZE_W-1:0]    key1,
    output bft_pkg::match_res_t           res
);

    logic [1:0]                 hits0_reg, hits0_next;
    logic [bft_pkg::SLOT_W-1:0] idx0_reg, idx0_next;
    logic                       hit1_reg, hit1_next;

    always_comb
    begin
        hits0_next = hits0_reg;
        idx0_next  = idx0_reg;
        hit1_next  = hit1_reg;
        if (ctl.clr)
        begin
            hits0_next = 2'd0;
            hit1_next  = 1'b0;
        end
        else if (ctl.valid)
        begin
            if (data == key0)
            begin
                if (hits0_reg == 2'd0)
                begin
                    idx0_next = ctl.idx;
                end
                if (hits0_reg != 2'd2)
                begin
                    hits0_next = hits0_reg + 2'd1;
                end
            end
            if (data == key1)
            begin
                hit1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits0_reg <= 2'd0;
            hit1_reg  <= 1'b0;
        end
        else
        begin
            hits0_reg <= hits0_next;
            hit1_reg  <= hit1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx0_reg <= idx0_next;
    end

    assign res.hits0 = hits0_reg;
    assign res.idx0  = idx0_reg;
    assign res.hit1  = hit1_reg;

endmodule

@@ sv/bin_fill_table_engine_unit.sv @@
`timescale 1ns / 1ps

// One request is taken at a time and answered with one result beat. Add bin, fit test and
// insert only load both table entries and execute. Contains walks the slots of the first bin,
// remove then also reads the last slot back into the freed one, move also appends the item to
// the second bin, and a swap between two bins walks both bins. Compact visits every bin in use
// and copies every bin it moves down slot by slot. Every slot walk and every bin copy passes
// through the single read port of the slot memory, one slot per cycle. A new request is taken
// while the previous result still waits on the output.
module bin_fill_table_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], first_bin[6:3], second_bin[10:7], first_item[26:11],
    // second_item[42:27], zero fill[47:43]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok[0], status[3:1], bin_count[8:4], first_bin_total[24:9], zero fill[31:25]
    output logic [31:0] m_axis_tdata
);

    localparam int SW = bft_pkg::SIZE_W;
    localparam int BW = bft_pkg::BIN_W;
    localparam int KW = bft_pkg::SLOT_W;
    localparam int CW = bft_pkg::CNT_W;
    localparam int NW = bft_pkg::NB_W;
    localparam int AW = bft_pkg::ADDR_W;
    localparam int UW = bft_pkg::SUM_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOADA    = 4'd1;
    localparam logic [3:0] S_LOADB    = 4'd2;
    localparam logic [3:0] S_EXEC     = 4'd3;
    localparam logic [3:0] S_SCANA    = 4'd4;
    localparam logic [3:0] S_SCANB    = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_RDLAST   = 4'd7;
    localparam logic [3:0] S_WRLAST   = 4'd8;
    localparam logic [3:0] S_APPEND   = 4'd9;
    localparam logic [3:0] S_SWAPB    = 4'd10;
    localparam logic [3:0] S_CMP_RD   = 4'd11;
    localparam logic [3:0] S_CMP_COPY = 4'd12;
    localparam logic [3:0] S_FINISH   = 4'd13;

    logic [3:0]                 state_reg, state_next;
    logic [bft_pkg::ACT_W-1:0]  op_reg, op_next;
    logic [BW-1:0]              ba_reg, ba_next, bb_reg, bb_next;
    logic [SW-1:0]              ia_reg, ia_next, ib_reg, ib_next;
    logic [SW-1:0]              ta_reg, ta_next, tb_reg, tb_next;
    logic [CW-1:0]              ca_reg, ca_next, cb_reg, cb_next;
    logic [bft_pkg::STS_W-1:0]  st_reg, st_next;
    logic [NW-1:0]              n_reg, n_next, r_reg, r_next, w_reg, w_next;
    logic [SW-1:0]              cap_reg, cap_next;
    logic [CW-1:0]              iss_reg, iss_next;
    logic                       pend_reg, pend_next;
    logic [KW-1:0]              pk_reg, pk_next;
    logic [KW-1:0]              idxa_reg, idxa_next, idxb_reg, idxb_next;
    logic                       ov_reg, ov_next;
    logic [31:0]                od_reg, od_next;

    logic [SW-1:0]              total_reg [bft_pkg::MAX_BINS];
    logic [CW-1:0]              count_reg [bft_pkg::MAX_BINS];

    logic [BW-1:0]              tab_ridx;
    logic [SW-1:0]              tab_t;
    logic [CW-1:0]              tab_c;
    logic                       tab_we;
    logic [BW-1:0]              tab_widx;
    logic [SW-1:0]              tab_wt;
    logic [CW-1:0]              tab_wc;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [SW-1:0]              mem_wdata, mem_rdata;

    bft_pkg::match_ctl_t        mctl;
    bft_pkg::match_res_t        mres;
    logic [SW-1:0]              key0;

    logic                       in_acc, ok_a, ok_b, same, scan_done, issue;
    logic [BW-1:0]              scan_bin;
    logic [CW-1:0]              scan_cnt;
    logic [UW-1:0]              fit_sum, move_sum, swap_ta, swap_tb;
    logic [1:0]                 need0;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    assign tab_t = total_reg[tab_ridx];
    assign tab_c = count_reg[tab_ridx];

    assign ok_a = NW'(ba_reg) < n_reg;
    assign ok_b = NW'(bb_reg) < n_reg;
    assign same = (ba_reg == bb_reg);

    assign fit_sum  = UW'(ta_reg) + UW'(ia_reg);
    assign move_sum = UW'(tb_reg) - (same ? UW'(ia_reg) : UW'(0)) + UW'(ia_reg);
    assign swap_ta  = UW'(ta_reg) - UW'(ia_reg) + UW'(ib_reg);
    assign swap_tb  = UW'(tb_reg) - UW'(ib_reg) + UW'(ia_reg);
    assign need0    = (ia_reg == ib_reg) ? 2'd2 : 2'd1;

    assign scan_bin  = (state_reg == S_SCANB) ? bb_reg : ba_reg;
    assign scan_cnt  = (state_reg == S_SCANB) ? cb_reg : ca_reg;
    assign issue     = (iss_reg < scan_cnt);
    assign scan_done = !issue && !pend_reg;
    assign key0      = (state_reg == S_SCANB) ? ib_reg : ia_reg;

    bft_slot_ram #(
        .ADDR_W (AW),
        .DATA_W (SW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bft_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .data  (mem_rdata),
        .key0  (key0),
        .key1  (ib_reg),
        .res   (mres)
    );

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ba_next    = ba_reg;
        bb_next    = bb_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        st_next    = st_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        cap_next   = cfg_valid ? cfg_data : cap_reg;
        iss_next   = iss_reg;
        pend_next  = 1'b0;
        pk_next    = iss_reg[KW-1:0];
        idxa_next  = idxa_reg;
        idxb_next  = idxb_reg;
        ov_next    = ov_reg && !m_axis_tready;
        od_next    = od_reg;

        tab_ridx  = ba_reg;
        tab_we    = 1'b0;
        tab_widx  = ba_reg;
        tab_wt    = '0;
        tab_wc    = '0;
        mem_we    = 1'b0;
        mem_waddr = {ba_reg, idxa_reg};
        mem_wdata = ia_reg;
        mem_raddr = {scan_bin, iss_reg[KW-1:0]};
        mctl.clr   = 1'b0;
        mctl.valid = 1'b0;
        mctl.idx   = pk_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next    = s_axis_tdata[2:0];
                    ba_next    = s_axis_tdata[6:3];
                    bb_next    = s_axis_tdata[10:7];
                    ia_next    = s_axis_tdata[26:11];
                    ib_next    = s_axis_tdata[42:27];
                    st_next    = bft_pkg::STS_OK;
                    state_next = S_LOADA;
                end
            end
            S_LOADA:
            begin
                ta_next    = tab_t;
                ca_next    = tab_c;
                state_next = S_LOADB;
            end
            S_LOADB:
            begin
                tab_ridx   = bb_reg;
                tb_next    = tab_t;
                cb_next    = tab_c;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                iss_next   = '0;
                mctl.clr   = 1'b1;
                state_next = S_FINISH;
                case (op_reg)
                    bft_pkg::OP_ADD_BIN:
                    begin
                        if (n_reg >= NW'(bft_pkg::MAX_BINS))
                        begin
                            st_next = bft_pkg::STS_FULL;
                        end
                        else
                        begin
                            tab_we   = 1'b1;
                            tab_widx = n_reg[BW-1:0];
                            n_next   = n_reg + NW'(1);
                        end
                    end
                    bft_pkg::OP_FIT:
                    begin
                        if (!ok_a)
                        begin
                            st_next = bft_pkg::STS_BAD_BIN;
                        end
                        else if (fit_sum > UW'(cap_reg))
                        begin
                            st_next = bft_pkg::STS_OVER_CAP;
                        end
                    end
                    bft_pkg::OP_INSERT:
                    begin
                        if (!ok_a)
                        begin
                            st_next = bft_pkg::STS_BAD_BIN;
                        end
                        else if (fit_sum > UW'(cap_reg))
                        begin
                            st_next = bft_pkg::STS_OVER_CAP;
                        end
                        else if (ca_reg >= CW'(bft_pkg::MAX_ITEMS))
                        begin
                            st_next = bft_pkg::STS_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {ba_reg, ca_reg[KW-1:0]};
                            tab_we    = 1'b1;
                            tab_wt    = fit_sum[SW-1:0];
                            tab_wc    = ca_reg + CW'(1);
                        end
                    end
                    bft_pkg::OP_COMPACT:
                    begin
                        r_next     = '0;
                        w_next     = '0;
                        state_next = S_CMP_RD;
                    end
                    default:
                    begin
                        if (!ok_a || (!ok_b && (op_reg == bft_pkg::OP_MOVE ||
                                                op_reg == bft_pkg::OP_SWAP)))
                        begin
                            st_next = bft_pkg::STS_BAD_BIN;
                        end
                        else
                        begin
                            state_next = S_SCANA;
                        end
                    end
                endcase
            end
            S_SCANA, S_SCANB:
            begin
                mctl.valid = pend_reg;
                if (issue)
                begin
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (scan_done)
                begin
                    if (state_reg == S_SCANA)
                    begin
                        idxa_next = mres.idx0;
                    end
                    else
                    begin
                        idxb_next = mres.idx0;
                    end
                    if (state_reg == S_SCANA && op_reg == bft_pkg::OP_SWAP && !same)
                    begin
                        if (mres.hits0 == 2'd0)
                        begin
                            st_next    = bft_pkg::STS_NOT_FOUND;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mctl.clr   = 1'b1;
                            iss_next   = '0;
                            state_next = S_SCANB;
                        end
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_FINISH;
                if (op_reg == bft_pkg::OP_SWAP && same &&
                    (mres.hits0 < need0 || !mres.hit1))
                begin
                    st_next = bft_pkg::STS_NOT_FOUND;
                end
                else if (mres.hits0 == 2'd0)
                begin
                    st_next = bft_pkg::STS_NOT_FOUND;
                end
                else
                begin
                    case (op_reg)
                        bft_pkg::OP_REMOVE:
                        begin
                            state_next = S_RDLAST;
                        end
                        bft_pkg::OP_MOVE:
                        begin
                            if (move_sum > UW'(cap_reg))
                            begin
                                st_next = bft_pkg::STS_OVER_CAP;
                            end
                            else if (!same && cb_reg >= CW'(bft_pkg::MAX_ITEMS))
                            begin
                                st_next = bft_pkg::STS_FULL;
                            end
                            else if (!same)
                            begin
                                state_next = S_RDLAST;
                            end
                        end
                        bft_pkg::OP_SWAP:
                        begin
                            if (same)
                            begin
                                if (ta_reg > cap_reg)
                                begin
                                    st_next = bft_pkg::STS_OVER_CAP;
                                end
                            end
                            else if (swap_ta > UW'(cap_reg) || swap_tb > UW'(cap_reg))
                            begin
                                st_next = bft_pkg::STS_OVER_CAP;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = ib_reg;
                                tab_we     = 1'b1;
                                tab_wt     = swap_ta[SW-1:0];
                                tab_wc     = ca_reg;
                                state_next = S_SWAPB;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWAPB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {bb_reg, idxb_reg};
                tab_we     = 1'b1;
                tab_widx   = bb_reg;
                tab_wt     = swap_tb[SW-1:0];
                tab_wc     = cb_reg;
                state_next = S_FINISH;
            end
            S_RDLAST:
            begin
                mem_raddr  = {ba_reg, KW'(ca_reg - CW'(1))};
                state_next = S_WRLAST;
            end
            S_WRLAST:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                tab_we     = 1'b1;
                tab_wt     = ta_reg - ia_reg;
                tab_wc     = ca_reg - CW'(1);
                state_next = (op_reg == bft_pkg::OP_MOVE) ? S_APPEND : S_FINISH;
            end
            S_APPEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {bb_reg, cb_reg[KW-1:0]};
                tab_we     = 1'b1;
                tab_widx   = bb_reg;
                tab_wt     = tb_reg + ia_reg;
                tab_wc     = cb_reg + CW'(1);
                state_next = S_FINISH;
            end
            S_CMP_RD:
            begin
                tab_ridx = r_reg[BW-1:0];
                iss_next = '0;
                if (r_reg == n_reg)
                begin
                    n_next     = w_reg;
                    state_next = S_FINISH;
                end
                else if (tab_t == '0)
                begin
                    r_next = r_reg + NW'(1);
                end
                else if (w_reg == r_reg)
                begin
                    r_next = r_reg + NW'(1);
                    w_next = w_reg + NW'(1);
                end
                else
                begin
                    tab_we     = 1'b1;
                    tab_widx   = w_reg[BW-1:0];
                    tab_wt     = tab_t;
                    tab_wc     = tab_c;
                    ca_next    = tab_c;
                    state_next = S_CMP_COPY;
                end
            end
            S_CMP_COPY:
            begin
                mem_raddr = {r_reg[BW-1:0], iss_reg[KW-1:0]};
                mem_waddr = {w_reg[BW-1:0], pk_reg};
                mem_wdata = mem_rdata;
                mem_we    = pend_reg;
                if (iss_reg < ca_reg)
                begin
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    r_next     = r_reg + NW'(1);
                    w_next     = w_reg + NW'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_FINISH:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = {7'd0, (ok_a ? tab_t : SW'(0)), n_reg, st_reg,
                                  (st_reg == bft_pkg::STS_OK)};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            cap_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < bft_pkg::MAX_BINS; i++)
            begin
                total_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            cap_reg   <= cap_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            if (tab_we)
            begin
                total_reg[tab_widx] <= tab_wt;
                count_reg[tab_widx] <= tab_wc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        ba_reg   <= ba_next;
        bb_reg   <= bb_next;
        ia_reg   <= ia_next;
        ib_reg   <= ib_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        st_reg   <= st_next;
        r_reg    <= r_next;
        w_reg    <= w_next;
        iss_reg  <= iss_next;
        pk_reg   <= pk_next;
        idxa_reg <= idxa_next;
        idxb_reg <= idxb_next;
        od_reg   <= od_next;
    end

endmodule

@@ sv/bft_checker.sv @@
`timescale 1ns / 1ps

module bft_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A result beat that is not taken stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The ok flag is set exactly when the status reports success.
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == bft_pkg::STS_OK)))
        else $error("ok flag disagrees with status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= bft_pkg::STS_FULL))
        else $error("status code out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:4] <= 5'd16))
        else $error("bin count out of range");

endmodule

bind bin_fill_table_engine_unit bft_checker u_bft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ sim/bin_fill_table_engine_unit_tb.sv @@
`timescale 1ns / 1ps

module bin_fill_table_engine_unit_tb;

    typedef struct packed {
        logic [15:0] second_item;
        logic [15:0] first_item;
        logic [3:0]  second_bin;
        logic [3:0]  first_bin;
        logic [2:0]  action;
    } bin_request_t;

    typedef struct packed {
        logic [15:0] total;
        logic [4:0]  count;
        logic [2:0]  status;
        logic        ok;
    } bin_reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    bin_fill_table_engine_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bin_request_t request_q[$];
    bin_reply_t   reply_q[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         hold_send;
    int           mismatches;

    int unsigned  capacity;
    int unsigned  bins_used;
    int unsigned  total_of[bft_pkg::MAX_BINS];
    int unsigned  fill_of[bft_pkg::MAX_BINS];
    int unsigned  sizes_of[bft_pkg::MAX_BINS][bft_pkg::MAX_ITEMS];

    function automatic int unsigned copies_in(int unsigned b, int unsigned v);
        int unsigned n;
        n = 0;
        for (int k = 0; k < fill_of[b]; k++)
            if (sizes_of[b][k] == v)
                n++;
        return n;
    endfunction

    task automatic take_size(int unsigned b, int unsigned v);
        for (int k = 0; k < fill_of[b]; k++)
        begin
            if (sizes_of[b][k] == v)
            begin
                sizes_of[b][k] = sizes_of[b][fill_of[b] - 1];
                fill_of[b]--;
                total_of[b] = (total_of[b] - v) & 16'hFFFF;
                return;
            end
        end
    endtask

    task automatic put_size(int unsigned b, int unsigned v);
        if (fill_of[b] < bft_pkg::MAX_ITEMS)
        begin
            sizes_of[b][fill_of[b]] = v;
            fill_of[b]++;
            total_of[b] = (total_of[b] + v) & 16'hFFFF;
        end
    endtask

    task automatic add_request(bin_request_t r);
        request_q.insert(request_q.size(), r);
    endtask

    task automatic table_apply(input bin_request_t rq, output bin_reply_t rp);
        int unsigned a, b, ia, ib, w;
        longint      ta, tb;
        logic [2:0]  st;
        bit          same;
        a    = rq.first_bin;
        b    = rq.second_bin;
        ia   = rq.first_item;
        ib   = rq.second_item;
        same = (a == b);
        st   = bft_pkg::STS_OK;
        case (rq.action)
            bft_pkg::OP_ADD_BIN:
                if (bins_used >= bft_pkg::MAX_BINS)
                    st = bft_pkg::STS_FULL;
                else
                begin
                    total_of[bins_used] = 0;
                    fill_of[bins_used]  = 0;
                    bins_used++;
                end
            bft_pkg::OP_CONTAINS:
                if (a >= bins_used) st = bft_pkg::STS_BAD_BIN;
                else if (copies_in(a, ia) == 0) st = bft_pkg::STS_NOT_FOUND;
            bft_pkg::OP_FIT:
                if (a >= bins_used) st = bft_pkg::STS_BAD_BIN;
                else if (longint'(total_of[a]) + ia > capacity) st = bft_pkg::STS_OVER_CAP;
            bft_pkg::OP_INSERT:
                if (a >= bins_used) st = bft_pkg::STS_BAD_BIN;
                else if (longint'(total_of[a]) + ia > capacity) st = bft_pkg::STS_OVER_CAP;
                else if (fill_of[a] >= bft_pkg::MAX_ITEMS) st = bft_pkg::STS_FULL;
                else put_size(a, ia);
            bft_pkg::OP_REMOVE:
                if (a >= bins_used) st = bft_pkg::STS_BAD_BIN;
                else if (copies_in(a, ia) == 0) st = bft_pkg::STS_NOT_FOUND;
                else take_size(a, ia);
            bft_pkg::OP_MOVE:
                if (a >= bins_used || b >= bins_used) st = bft_pkg::STS_BAD_BIN;
                else if (copies_in(a, ia) == 0) st = bft_pkg::STS_NOT_FOUND;
                else
                begin
                    tb = longint'(total_of[b]) - (same ? ia : 0);
                    if (tb + ia > capacity) st = bft_pkg::STS_OVER_CAP;
                    else if (fill_of[b] - (same ? 1 : 0) >= bft_pkg::MAX_ITEMS)
                        st = bft_pkg::STS_FULL;
                    else
                    begin
                        take_size(a, ia);
                        put_size(b, ia);
                    end
                end
            bft_pkg::OP_SWAP:
                if (a >= bins_used || b >= bins_used) st = bft_pkg::STS_BAD_BIN;
                else if (same && (copies_in(a, ia) < (ia == ib ? 2 : 1)
                                  || copies_in(a, ib) == 0)) st = bft_pkg::STS_NOT_FOUND;
                else if (!same && (copies_in(a, ia) == 0 || copies_in(b, ib) == 0))
                    st = bft_pkg::STS_NOT_FOUND;
                else
                begin
                    ta = longint'(total_of[a]) - ia - (same ? ib : 0) + ib;
                    tb = (same ? ta : longint'(total_of[b]) - ib) + ia;
                    if (ta > capacity || tb > capacity) st = bft_pkg::STS_OVER_CAP;
                    else
                    begin
                        take_size(a, ia);
                        take_size(b, ib);
                        put_size(a, ib);
                        put_size(b, ia);
                    end
                end
            default:
            begin
                w = 0;
                for (int r = 0; r < bins_used; r++)
                begin
                    if (total_of[r] != 0)
                    begin
                        total_of[w] = total_of[r];
                        fill_of[w]  = fill_of[r];
                        for (int k = 0; k < bft_pkg::MAX_ITEMS; k++)
                            sizes_of[w][k] = sizes_of[r][k];
                        w++;
                    end
                end
                bins_used = w;
            end
        endcase
        rp.ok     = (st == bft_pkg::STS_OK);
        rp.status = st;
        rp.count  = 5'(bins_used);
        rp.total  = (a < bins_used) ? total_of[a][15:0] : 16'd0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bin_reply_t rp;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                table_apply(bin_request_t'(s_axis_tdata[42:0]), rp);
                reply_q.insert(reply_q.size(), rp);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_q.size() > 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata  <= {5'd0, request_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        bin_reply_t got, want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[24:0];
                if (reply_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat %h.", got);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.ok !== want.ok || got.status !== want.status
                        || got.count !== want.count || got.total !== want.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected ok=%0d st=%0d n=%0d tot=%0d, got ok=%0d st=%0d n=%0d tot=%0d.",
                                     want.ok, want.status, want.count, want.total,
                                     got.ok, got.status, got.count, got.total);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic bin_request_t make_req(logic [2:0] act, int b1, int b2,
                                              int i1, int i2);
        bin_request_t r;
        r.action      = act;
        r.first_bin   = 4'(b1);
        r.second_bin  = 4'(b2);
        r.first_item  = 16'(i1);
        r.second_item = 16'(i2);
        return r;
    endfunction

    function automatic int pick_size();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(65535);
            3: return $urandom_range(30000, 40000);
            default: return $urandom_range(1, 6) * 50;
        endcase
    endfunction

    function automatic int pick_bin();
        return ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5);
    endfunction

    task automatic wait_idle();
        while (request_q.size() > 0 || reply_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_capacity(int unsigned v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= 16'(v);
        do @(posedge clk); while (!cfg_ready);
        capacity = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_random(int n);
        int left, b, b2, k;
        left = n;
        while (left > 0)
        begin
            b  = pick_bin();
            b2 = pick_bin();
            case ($urandom_range(9))
                0:
                begin
                    k = $urandom_range(1, 4);
                    repeat (k) add_request(make_req(bft_pkg::OP_ADD_BIN, $urandom_range(15),
                        $urandom_range(15), $urandom_range(65535), $urandom_range(65535)));
                    left -= k;
                end
                1, 2:
                begin
                    k = $urandom_range(3, 17);
                    repeat (k) add_request(make_req(bft_pkg::OP_INSERT, b,
                        $urandom_range(15), pick_size(), $urandom_range(65535)));
                    left -= k;
                end
                3:
                begin
                    k = $urandom_range(2, 6);
                    repeat (k) add_request(make_req(bft_pkg::OP_REMOVE, b,
                        $urandom_range(15), pick_size(), $urandom_range(65535)));
                    left -= k;
                end
                4, 5:
                begin
                    add_request(make_req(bft_pkg::OP_MOVE, b, b2, pick_size(),
                        $urandom_range(65535)));
                    add_request(make_req(bft_pkg::OP_SWAP, b,
                        ($urandom_range(3) == 0) ? b : b2, pick_size(), pick_size()));
                    left -= 2;
                end
                6:
                begin
                    add_request(make_req(bft_pkg::OP_CONTAINS, b, b2, pick_size(),
                        $urandom_range(65535)));
                    add_request(make_req(bft_pkg::OP_FIT, b, b2, pick_size(),
                        $urandom_range(65535)));
                    left -= 2;
                end
                7:
                begin
                    add_request(make_req(bft_pkg::OP_COMPACT, b, b2, $urandom_range(65535),
                        $urandom_range(65535)));
                    left -= 1;
                end
                default:
                begin
                    add_request(make_req(3'($urandom_range(7)), $urandom_range(15),
                        $urandom_range(15), $urandom_range(65535), $urandom_range(65535)));
                    left -= 1;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tdata  = '0;
        hold_send     = 1'b0;
        mismatches    = 0;
        send_idle_pct = 10;
        recv_idle_pct = 67;
        capacity      = 0;
        bins_used     = 0;
        for (int i = 0; i < bft_pkg::MAX_BINS; i++)
        begin
            total_of[i] = 0;
            fill_of[i]  = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_request(make_req(bft_pkg::OP_CONTAINS, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_COMPACT, 15, 15, 65535, 65535));
        add_request(make_req(bft_pkg::OP_ADD_BIN, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_FIT, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_INSERT, 0, 0, 1, 0));
        add_request(make_req(bft_pkg::OP_INSERT, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_MOVE, 0, 1, 0, 0));
        write_capacity(65535);
        add_request(make_req(bft_pkg::OP_ADD_BIN, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_INSERT, 0, 0, 65535, 0));
        add_request(make_req(bft_pkg::OP_FIT, 0, 0, 1, 0));
        add_request(make_req(bft_pkg::OP_INSERT, 1, 0, 7, 0));
        add_request(make_req(bft_pkg::OP_INSERT, 1, 0, 7, 0));
        add_request(make_req(bft_pkg::OP_SWAP, 1, 1, 7, 7));
        add_request(make_req(bft_pkg::OP_SWAP, 0, 1, 65535, 7));
        add_request(make_req(bft_pkg::OP_SWAP, 0, 1, 5, 7));
        add_request(make_req(bft_pkg::OP_MOVE, 1, 1, 7, 0));
        add_request(make_req(bft_pkg::OP_MOVE, 1, 0, 65535, 0));
        add_request(make_req(bft_pkg::OP_REMOVE, 0, 0, 3, 0));
        add_request(make_req(bft_pkg::OP_CONTAINS, 1, 0, 65535, 0));
        add_request(make_req(bft_pkg::OP_ADD_BIN, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_COMPACT, 2, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_CONTAINS, 2, 0, 0, 0));
        repeat (14) add_request(make_req(bft_pkg::OP_ADD_BIN, 0, 0, 0, 0));
        add_request(make_req(bft_pkg::OP_COMPACT, 0, 0, 0, 0));

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 67 : 0;
            recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 10 : 0;
            for (int c = 0; c < 4; c++)
            begin
                case (c)
                    0: write_capacity(0);
                    1: write_capacity(65535);
                    2: write_capacity($urandom_range(500, 2000));
                    default: write_capacity($urandom_range(65535));
                endcase
                add_request(make_req(bft_pkg::OP_COMPACT, 0, 0, 0, 0));
                repeat (4) add_request(make_req(bft_pkg::OP_ADD_BIN, 0, 0, 0, 0));
                fill_random(45);
                if (mode == 1 && c == 1)
                begin
                    while (request_q.size() > 20)
                        @(posedge clk);
                    hold_send = 1'b1;
                    while (reply_q.size() > 0 || s_axis_tvalid)
                        @(posedge clk);
                    hold_send = 1'b0;
                end
                fill_random(45);
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("bin_fill_table_engine_unit test passed");
        else
            $display("bin_fill_table_engine_unit test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("bin_fill_table_engine_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bft_pkg.sv
sv/bft_slot_ram.sv
sv/bft_match.sv
sv/bin_fill_table_engine_unit.sv
sv/bft_checker.sv
sim/bin_fill_table_engine_unit_tb.sv
